>>> sv/fsge_pkg.sv
// Shared types, constants and level helpers for the four-state gate evaluator.
// No dependencies; every other file imports this package.
package fsge_pkg;

  localparam int unsigned SLOTS      = 16;
  localparam int unsigned SLOT_W     = $clog2(SLOTS);
  localparam int unsigned LEVELS_W   = 2 * SLOTS;
  localparam int unsigned MAX_INPUTS = 16;
  localparam int unsigned EFF_INPUTS = (MAX_INPUTS < SLOTS) ? MAX_INPUTS : SLOTS;
  localparam int unsigned ACTION_W   = 4;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned OUT_SLOTS  = 4;
  localparam int unsigned OUT_W      = 2 * OUT_SLOTS;
  localparam int unsigned OCNT_W     = 3;

  typedef enum logic [1:0] {
    LV_L = 2'd0,
    LV_H = 2'd1,
    LV_X = 2'd2,
    LV_Z = 2'd3
  } level_e;

  typedef enum logic [ACTION_W-1:0] {
    GT_AND   = 4'd0,
    GT_OR    = 4'd1,
    GT_XOR   = 4'd2,
    GT_NAND  = 4'd3,
    GT_NOR   = 4'd4,
    GT_NOT   = 4'd5,
    GT_BUF   = 4'd6,
    GT_TBUF  = 4'd7,
    GT_OC    = 4'd8,
    GT_MUX2  = 4'd9,
    GT_MUX4  = 4'd10,
    GT_DMUX2 = 4'd11,
    GT_DMUX4 = 4'd12
  } gate_e;

  typedef logic [LEVELS_W-1:0] levels_t;
  typedef logic [SLOTS-1:0]    slot_mask_t;

  // Decode stage word: raw levels plus per-slot class flags of counted inputs
  typedef struct packed {
    gate_e      act;
    logic       alow;
    levels_t    lv;
    slot_mask_t is_l;
    slot_mask_t is_h;
    slot_mask_t is_x;
  } dec_t;

  // Reduce stage word: reduction flags plus result of the non-reducing gates
  typedef struct packed {
    gate_e              act;
    logic               any_l;
    logic               any_h;
    logic               any_x;
    logic               parity;
    logic [OUT_W-1:0]   res;
    logic [OCNT_W-1:0]  nout;
  } red_t;

  typedef struct packed {
    logic [OUT_W-1:0]  levels;
    logic [OCNT_W-1:0] count;
  } res_t;

  function automatic level_e lv_at(levels_t lv, logic [SLOT_W-1:0] k);
    return level_e'(lv[{k, 1'b0} +: 2]);
  endfunction

  // Z on a logic input counts as X
  function automatic level_e lv_bin(level_e a);
    return (a == LV_Z) ? LV_X : a;
  endfunction

  function automatic level_e lv_not(level_e a);
    level_e r;
    r = LV_X;
    if (a == LV_L) r = LV_H;
    else if (a == LV_H) r = LV_L;
    return r;
  endfunction

endpackage

>>> sv/fsge_if.sv
// Valid/ready channel interfaces for the gate evaluator's request and result words.
// Depends on fsge_pkg for field widths.
interface fsge_in_if import fsge_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [CNT_W-1:0]    input_count;
  logic [LEVELS_W-1:0] input_levels;
  logic                enable_active_low;

  modport source (output valid, action, input_count, input_levels, enable_active_low,
                  input ready);
  modport sink   (input valid, action, input_count, input_levels, enable_active_low,
                  output ready);
endinterface

interface fsge_out_if import fsge_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OUT_W-1:0]  output_levels;
  logic [OCNT_W-1:0] output_count;

  modport source (output valid, output_levels, output_count, input ready);
  modport sink   (input valid, output_levels, output_count, output ready);
endinterface

>>> sv/fsge_decode.sv
// Stage 1: clamp the input count and classify each counted input slot.
// Depends on fsge_pkg.
module fsge_decode import fsge_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  gate_e            act_i,
  input  logic [CNT_W-1:0] cnt_i,
  input  levels_t          lv_i,
  input  logic             alow_i,
  output logic             valid_o,
  input  logic             ready_i,
  output dec_t             data_o
);

  logic             valid_q;
  dec_t             data_d, data_q;
  logic [CNT_W-1:0] n;

  always_comb begin
    level_e lvl;
    lvl = LV_X;
    n = (cnt_i > CNT_W'(EFF_INPUTS)) ? CNT_W'(EFF_INPUTS) : cnt_i;
    data_d.act  = act_i;
    data_d.alow = alow_i;
    data_d.lv   = lv_i;
    for (int k = 0; k < SLOTS; k++) begin
      lvl = lv_bin(lv_at(lv_i, SLOT_W'(k)));
      data_d.is_l[k] = (CNT_W'(k) < n) && (lvl == LV_L);
      data_d.is_h[k] = (CNT_W'(k) < n) && (lvl == LV_H);
      data_d.is_x[k] = (CNT_W'(k) < n) && (lvl == LV_X);
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> sv/fsge_reduce.sv
// Stage 2: reduce slot flags; evaluate TBUF, OC, NOT, BUF, mux and demux gates.
// Depends on fsge_pkg.
module fsge_reduce import fsge_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  dec_t data_i,
  output logic valid_o,
  input  logic ready_i,
  output red_t data_o
);

  logic   valid_q;
  red_t   data_d, data_q;
  level_e res [OUT_SLOTS];

  always_comb begin
    logic                 dem, four, first;
    logic [1:0]           cc;
    logic [OUT_SLOTS-1:0] allow;
    level_e               s0, s1, en, cand, mv;
    level_e               dv [OUT_SLOTS];
    dem   = (data_i.act == GT_DMUX2) || (data_i.act == GT_DMUX4);
    four  = (data_i.act == GT_MUX4) || (data_i.act == GT_DMUX4);
    s0    = lv_bin(lv_at(data_i.lv, dem ? SLOT_W'(1) : (four ? SLOT_W'(4) : SLOT_W'(2))));
    s1    = lv_bin(lv_at(data_i.lv, dem ? SLOT_W'(2) : SLOT_W'(5)));
    en    = lv_bin(lv_at(data_i.lv, SLOT_W'(1)));
    cand  = LV_X;
    cc    = 2'd0;
    first = 1'b1;
    mv    = LV_X;

    // Candidates that the select allows; an X select bit allows both halves
    for (int c = 0; c < OUT_SLOTS; c++) begin
      cc = 2'(c);
      allow[c] = (c < 2 || four)
              && (s0 == LV_X || s0 == level_e'({1'b0, cc[0]}))
              && (!four || s1 == LV_X || s1 == level_e'({1'b0, cc[1]}));
    end

    // Mux: merge allowed data inputs, disagreement gives X
    for (int c = 0; c < OUT_SLOTS; c++) begin
      if (allow[c]) begin
        cand  = lv_bin(lv_at(data_i.lv, SLOT_W'(c)));
        mv    = (first || mv == cand) ? cand : LV_X;
        first = 1'b0;
      end
    end

    // Demux: each output merges data (when it is the candidate) or L
    for (int p = 0; p < OUT_SLOTS; p++) begin
      first = 1'b1;
      dv[p] = LV_X;
      for (int c = 0; c < OUT_SLOTS; c++) begin
        if (allow[c]) begin
          cand  = (p == c) ? lv_bin(lv_at(data_i.lv, SLOT_W'(0))) : LV_L;
          dv[p] = (first || dv[p] == cand) ? cand : LV_X;
          first = 1'b0;
        end
      end
    end

    for (int p = 0; p < OUT_SLOTS; p++) begin
      res[p] = LV_X;
    end
    data_d.nout = OCNT_W'(1);
    if (data_i.alow) en = lv_not(en);

    unique case (data_i.act) inside
      GT_TBUF: res[0] = (en == LV_H) ? lv_at(data_i.lv, SLOT_W'(0)) : LV_Z;
      GT_OC:   res[0] = (lv_at(data_i.lv, SLOT_W'(0)) == LV_H) ? LV_L : LV_Z;
      GT_NOT:  res[0] = lv_not(lv_bin(lv_at(data_i.lv, SLOT_W'(0))));
      GT_BUF:  res[0] = lv_bin(lv_at(data_i.lv, SLOT_W'(0)));
      GT_MUX2, GT_MUX4: res[0] = mv;
      GT_DMUX2, GT_DMUX4: begin
        for (int p = 0; p < OUT_SLOTS; p++) begin
          res[p] = dv[p];
        end
        data_d.nout = four ? OCNT_W'(4) : OCNT_W'(2);
      end
      default: res[0] = LV_X;
    endcase

    data_d.act    = data_i.act;
    data_d.any_l  = |data_i.is_l;
    data_d.any_h  = |data_i.is_h;
    data_d.any_x  = |data_i.is_x;
    data_d.parity = ^data_i.is_h;
    for (int p = 0; p < OUT_SLOTS; p++) begin
      data_d.res[2*p +: 2] = res[p];
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> sv/fsge_pack.sv
// Stage 3: resolve the multi-input gates, pack the outputs and hold the result word.
// Depends on fsge_pkg.
module fsge_pack import fsge_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  red_t data_i,
  output logic valid_o,
  input  logic ready_i,
  output res_t data_o
);

  logic             valid_q;
  res_t             data_d, data_q;
  level_e           r;
  logic [OUT_W-1:0] keep;

  always_comb begin
    unique case (data_i.act) inside
      GT_AND, GT_NAND: r = data_i.any_l ? LV_L : (data_i.any_x ? LV_X : LV_H);
      GT_OR, GT_NOR:   r = data_i.any_h ? LV_H : (data_i.any_x ? LV_X : LV_L);
      GT_XOR:          r = data_i.any_x ? LV_X : (data_i.parity ? LV_H : LV_L);
      default:         r = level_e'(data_i.res[1:0]);
    endcase
    if (data_i.act == GT_NAND || data_i.act == GT_NOR) r = lv_not(r);

    // Zero the slots above the output count
    keep = (data_i.nout == OCNT_W'(4)) ? {OUT_W{1'b1}}
         : (data_i.nout == OCNT_W'(2)) ? OUT_W'(8'h0F) : OUT_W'(8'h03);
    data_d.levels = {data_i.res[OUT_W-1:2], r} & keep;
    data_d.count  = data_i.nout;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> sv/four_state_gate_evaluator.sv
// Top level of the four-state gate evaluator: three-stage valid/ready pipeline.
// Depends on fsge_pkg, fsge_if, fsge_decode, fsge_reduce and fsge_pack.
//
//   channel | dir | word fields
//   --------+-----+------------------------------------------------------------
//   in_i    | in  | action, input_count, input_levels, enable_active_low
//   out_o   | out | output_levels, output_count
//
// One word per cycle is accepted and one result per cycle is delivered while out_o.ready
// stays high. Each word passes through the decode, reduce and pack registers in that
// order, and out_o.valid rises once the pack register holds its result. Each stage
// holds its word while the next one is full, so in_i.ready drops only when all three
// stages hold words and out_o.ready is low.
// Reset clears the stage valid bits only; the payload registers need no reset.
module four_state_gate_evaluator import fsge_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  fsge_in_if.sink    in_i,
  fsge_out_if.source out_o
);

  // Stage handshakes: valid flows down, ready flows back up
  logic s1_valid, s1_ready;
  logic s2_valid, s2_ready;
  logic s3_valid;
  dec_t s1_data;
  red_t s2_data;
  res_t s3_data;

  // Decode: clamp the count, mark each counted slot as L, H or X
  fsge_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .act_i   (gate_e'(in_i.action)),
    .cnt_i   (in_i.input_count),
    .lv_i    (in_i.input_levels),
    .alow_i  (in_i.enable_active_low),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .data_o  (s1_data)
  );

  // Reduce: OR/XOR trees over the flags, plus tristate, open collector,
  // inverter, buffer, mux and demux results
  fsge_reduce u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .data_o  (s2_data)
  );

  // Pack: pick the gate result, invert for NAND/NOR, mask unused slots.
  // Its register is the output register.
  fsge_pack u_pack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .data_i  (s2_data),
    .valid_o (s3_valid),
    .ready_i (out_o.ready),
    .data_o  (s3_data)
  );

  assign out_o.valid         = s3_valid;
  assign out_o.output_levels = s3_data.levels;
  assign out_o.output_count  = s3_data.count;

  // Backpressure reaches the input only with every stage full and the output stalled
  a_full_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (s1_valid && s2_valid && s3_valid && !out_o.ready))
    else $error("input stalled while a pipeline stage is empty");

  // A stalled reduce word must hold until the pack stage takes it
  a_s2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid && !s2_ready) |=> (s2_valid && $stable(s2_data)))
    else $error("reduce stage word changed while stalled");

  // Output count is one, two or four
  a_count_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid |-> (s3_data.count == OCNT_W'(1) || s3_data.count == OCNT_W'(2)
               || s3_data.count == OCNT_W'(4)))
    else $error("illegal output count");

  // Slots above the count read as zero
  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_valid && s3_data.count != OCNT_W'(4)) |->
      (s3_data.levels[OUT_W-1:4] == '0
       && (s3_data.count == OCNT_W'(2) || s3_data.levels[3:2] == 2'b00)))
    else $error("unused output slot not zero");

endmodule
